// ===== rtl/leg_pkg.sv =====
package leg_pkg;

  // Default widths of the envelope arithmetic.
  localparam int LENGTH_BITS_DEFAULT   = 16;
  localparam int FRACTION_BITS_DEFAULT = 23;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int LEVEL_W     = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_MODE          = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_LENGTH  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_LENGTH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_START_AMP     = 3'd4;

  // Q1.15 unity level.
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'h8000;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] TOTAL_LENGTH_RESET   = 16'd64;
  localparam logic [CFG_DATA_W-1:0] ATTACK_LENGTH_RESET  = 16'd16;
  localparam logic [CFG_DATA_W-1:0] RELEASE_LENGTH_RESET = 16'd16;
  localparam logic [CFG_DATA_W-1:0] START_AMP_RESET      = 16'h8000;

  typedef enum logic [1:0] {
    MODE_FULL     = 2'd0,
    MODE_ATTACK   = 2'd1,
    MODE_LONG_REL = 2'd2,
    MODE_REL_ONLY = 2'd3
  } leg_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_WAIT,
    ST_RAMP_GO,
    ST_RAMP_WAIT,
    ST_REL_GO,
    ST_REL_WAIT,
    ST_FIRST_OUT
  } leg_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;       // capture the registers and start a new envelope
    logic div_start;   // launch the step division
    logic sel_rel;     // divide for the release step of full mode
    logic store_ramp;  // keep the quotient as the ramp step
    logic store_rel;   // keep the quotient as the release step
    logic emit;        // produce one sample into the output register
  } leg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cfg_error;
    logic full_mode;
    logic div_done;
  } leg_status_t;

endpackage

// ===== rtl/leg_divider.sv =====
module leg_divider import leg_pkg::*; #(
  parameter int LENGTH_BITS   = LENGTH_BITS_DEFAULT,
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [FRACTION_BITS:0]   dividend_i,
  input  logic [LENGTH_BITS-1:0]   divisor_i,
  output logic                     done_o,
  output logic [FRACTION_BITS:0]   quotient_o
);

  localparam int QW    = FRACTION_BITS + 1;
  localparam int CNT_W = $clog2(QW);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic [LENGTH_BITS-1:0] den_q;
  logic [QW-1:0]          quo_q, quo_d;
  logic [LENGTH_BITS:0]   rem_shift;
  logic [LENGTH_BITS:0]   rem_diff;
  logic                   fits;

  // One quotient bit per cycle, restoring division.
  always_comb begin
    rem_shift = {rem_q, quo_q[QW-1]};
    rem_diff  = rem_shift - {1'b0, den_q};
    fits      = rem_shift >= {1'b0, den_q};
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? rem_diff[LENGTH_BITS-1:0] : rem_shift[LENGTH_BITS-1:0];
      quo_d = {quo_q[QW-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/leg_datapath.sv =====
module leg_datapath import leg_pkg::*; #(
  parameter int LENGTH_BITS   = LENGTH_BITS_DEFAULT,
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  leg_cmd_t               cmd_i,
  output leg_status_t            status_o,
  output logic [LEVEL_W-1:0]     level_o,
  output logic                   last_o,
  output logic                   config_error_o
);

  localparam int LW    = LENGTH_BITS;
  localparam int LW1   = LENGTH_BITS + 1;
  localparam int ACC_W = FRACTION_BITS + 1;
  localparam int SH    = FRACTION_BITS - 15;
  localparam logic [ACC_W-1:0] ONE = ACC_W'(1) << FRACTION_BITS;

  typedef enum logic [1:0] {
    KIND_HOLD,
    KIND_UP,
    KIND_DOWN
  } kind_e;

  // Programmable registers.
  leg_mode_e             mode_q;
  logic [CFG_DATA_W-1:0] total_q, attack_q, release_q, amp_q;

  // Values latched at restart.
  leg_mode_e         lt_mode_q;
  logic [LW-1:0]     lt_total_q, lt_attack_q, lt_release_q, env_len_q;
  logic [ACC_W-1:0]  lt_amp_q;

  // Envelope state.
  logic              finished_q;
  logic              err_flag_q;
  logic [LEVEL_W-1:0] held_q;
  logic [LW-1:0]     idx_q;
  logic [ACC_W-1:0]  acc_q, ramp_q, rel_q;

  // Output register.
  logic [LEVEL_W-1:0] level_q;
  logic               last_q;
  logic               cerr_q;

  logic [LW-1:0]     t_raw, a_raw, r_raw, env_d;
  logic              err_d;
  logic [CFG_DATA_W-1:0] amp_sat;
  logic [ACC_W-1:0]  amp_d;

  logic [ACC_W-1:0]  div_num;
  logic [LW-1:0]     div_den;
  logic              div_done;
  logic [ACC_W-1:0]  div_quo;

  kind_e             kind;
  logic              init;
  logic              use_rel;
  logic [ACC_W-1:0]  init_val, cval, acc_in, step, acc_next, val;
  logic [ACC_W:0]    sum;
  logic [LW-1:0]     knee, rel_j;
  logic [ACC_W-1:0]  rel_amp;
  logic              in_shape;
  logic [LW1-1:0]    idx_p1, idx_p2, rel_j_p2;
  logic [LEVEL_W-1:0] lvl;
  logic              last_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_FULL;
      total_q   <= TOTAL_LENGTH_RESET;
      attack_q  <= ATTACK_LENGTH_RESET;
      release_q <= RELEASE_LENGTH_RESET;
      amp_q     <= START_AMP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:           mode_q    <= leg_mode_e'(cfg_data_i[1:0]);
        REG_TOTAL_LENGTH:   total_q   <= cfg_data_i;
        REG_ATTACK_LENGTH:  attack_q  <= cfg_data_i;
        REG_RELEASE_LENGTH: release_q <= cfg_data_i;
        REG_START_AMP:      amp_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Length check and envelope length for the programmed mode.
  always_comb begin
    t_raw   = LW'(total_q);
    a_raw   = LW'(attack_q);
    r_raw   = LW'(release_q);
    amp_sat = (amp_q > LEVEL_ONE) ? LEVEL_ONE : amp_q;
    amp_d   = ACC_W'(amp_sat) << SH;
    case (mode_q)
      MODE_FULL: begin
        err_d = (a_raw < LW'(3)) || (r_raw < LW'(3)) ||
                (LW1'(t_raw) < (LW1'(a_raw) + LW1'(r_raw)));
        env_d = t_raw;
      end
      MODE_ATTACK: begin
        err_d = a_raw < LW'(5);
        env_d = a_raw;
      end
      MODE_LONG_REL: begin
        err_d = (r_raw < LW'(5)) || (t_raw < r_raw);
        env_d = t_raw;
      end
      default: begin
        err_d = r_raw < LW'(5);
        env_d = r_raw;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      lt_mode_q    <= mode_q;
      lt_total_q   <= t_raw;
      lt_attack_q  <= a_raw;
      lt_release_q <= r_raw;
      lt_amp_q     <= amp_d;
      env_len_q    <= env_d;
    end
  end

  // Ramps span each segment minus its held samples: two in full mode, four otherwise.
  always_comb begin
    div_num = (lt_mode_q == MODE_REL_ONLY) ? lt_amp_q : ONE;
    case (lt_mode_q)
      MODE_FULL:   div_den = cmd_i.sel_rel ? lt_release_q - LW'(2) : lt_attack_q - LW'(2);
      MODE_ATTACK: div_den = lt_attack_q - LW'(4);
      default:     div_den = lt_release_q - LW'(4);
    endcase
  end

  leg_divider #(
    .LENGTH_BITS   (LENGTH_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Segment decode and ramp arithmetic for the current sample.
  always_comb begin
    idx_p1   = LW1'(idx_q) + LW1'(1);
    idx_p2   = LW1'(idx_q) + LW1'(2);
    knee     = lt_total_q - lt_release_q;
    rel_j    = (lt_mode_q == MODE_LONG_REL) ? idx_q - knee : idx_q;
    rel_j_p2 = LW1'(rel_j) + LW1'(2);
    rel_amp  = (lt_mode_q == MODE_LONG_REL) ? ONE : lt_amp_q;
    kind     = KIND_HOLD;
    init     = 1'b0;
    init_val = '0;
    cval     = '0;
    use_rel  = 1'b0;
    in_shape = 1'b0;
    case (lt_mode_q)
      MODE_FULL: begin
        if (idx_q < LW'(2)) begin
          cval = '0;
        end else if (idx_q < lt_attack_q) begin
          kind = KIND_UP;
          init = idx_q == LW'(2);
        end else if (idx_q < knee) begin
          cval = ONE;
        end else if (idx_p2 < LW1'(lt_total_q)) begin
          kind     = KIND_DOWN;
          init     = idx_q == knee;
          init_val = ONE;
          use_rel  = 1'b1;
        end
      end
      MODE_ATTACK: begin
        if (idx_q < LW'(2)) begin
          cval = '0;
        end else if (idx_p2 < LW1'(lt_attack_q)) begin
          kind = KIND_UP;
          init = idx_q == LW'(2);
        end else begin
          cval = ONE;
        end
      end
      MODE_LONG_REL: begin
        if (idx_q < knee) begin
          cval = ONE;
        end else begin
          in_shape = 1'b1;
        end
      end
      default: begin
        in_shape = 1'b1;
      end
    endcase
    // Release shape: two samples at the start level, a falling ramp, two zeros.
    if (in_shape) begin
      if (rel_j < LW'(2)) begin
        cval = rel_amp;
      end else if (rel_j_p2 < LW1'(lt_release_q)) begin
        kind     = KIND_DOWN;
        init     = rel_j == LW'(2);
        init_val = rel_amp;
      end
    end

    acc_in = init ? init_val : acc_q;
    step   = use_rel ? rel_q : ramp_q;
    sum    = {1'b0, acc_in} + {1'b0, step};
    case (kind)
      KIND_UP: begin
        val      = acc_in;
        acc_next = (sum > {1'b0, ONE}) ? ONE : sum[ACC_W-1:0];
      end
      KIND_DOWN: begin
        acc_next = (acc_in > step) ? acc_in - step : '0;
        val      = acc_next;
      end
      default: begin
        val      = cval;
        acc_next = acc_q;
      end
    endcase
    lvl      = val[FRACTION_BITS -: LEVEL_W];
    last_now = idx_p1 >= LW1'(env_len_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      finished_q <= 1'b1;
      err_flag_q <= 1'b0;
      held_q     <= '0;
      idx_q      <= '0;
      acc_q      <= '0;
      ramp_q     <= '0;
      rel_q      <= '0;
    end else begin
      if (cmd_i.latch) begin
        finished_q <= err_d;
        err_flag_q <= err_d;
        held_q     <= '0;
        idx_q      <= '0;
        acc_q      <= '0;
        ramp_q     <= '0;
        rel_q      <= '0;
      end
      if (cmd_i.store_ramp) begin
        ramp_q <= div_quo;
      end
      if (cmd_i.store_rel) begin
        rel_q <= div_quo;
      end
      if (cmd_i.emit && !finished_q) begin
        acc_q <= acc_next;
        if (last_now) begin
          finished_q <= 1'b1;
          held_q     <= lvl;
        end else begin
          idx_q <= idx_q + LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (finished_q) begin
        level_q <= held_q;
        last_q  <= 1'b1;
        cerr_q  <= err_flag_q;
      end else begin
        level_q <= lvl;
        last_q  <= last_now;
        cerr_q  <= 1'b0;
      end
    end
  end

  assign status_o.cfg_error = err_flag_q;
  assign status_o.full_mode = lt_mode_q == MODE_FULL;
  assign status_o.div_done  = div_done;
  assign level_o            = level_q;
  assign last_o             = last_q;
  assign config_error_o     = cerr_q;

  // A rejected configuration leaves the envelope finished until the next restart.
  a_err_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_flag_q |-> finished_q)
    else $error("error flag set on a running envelope");

  // The accumulator never rises above unity.
  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= ONE)
    else $error("ramp accumulator above one");

  // Once finished, every sample repeats the held level.
  a_hold_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && finished_q |=> level_q == $past(held_q) && last_q)
    else $error("finished envelope did not repeat its final level");

  // A running envelope never reports a configuration error.
  a_run_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && !finished_q |=> !cerr_q)
    else $error("error reported on a running sample");

endmodule

// ===== rtl/leg_ctrl.sv =====
module leg_ctrl import leg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        restart_i,
  input  logic        out_stall_i,
  input  leg_status_t status_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  output leg_cmd_t    cmd_o
);

  leg_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (restart_i) begin
            cmd_o.latch = 1'b1;
            state_d     = ST_RAMP_GO;
          end else if (out_free) begin
            cmd_o.emit = 1'b1;
          end else begin
            state_d = ST_TICK_WAIT;
          end
        end
      end
      ST_TICK_WAIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_RAMP_GO: begin
        if (status_i.cfg_error) begin
          state_d = ST_FIRST_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_RAMP_WAIT;
        end
      end
      ST_RAMP_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.store_ramp = 1'b1;
          state_d = status_i.full_mode ? ST_REL_GO : ST_FIRST_OUT;
        end
      end
      ST_REL_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.sel_rel   = 1'b1;
        state_d         = ST_REL_WAIT;
      end
      ST_REL_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.store_rel = 1'b1;
          state_d         = ST_FIRST_OUT;
        end
      end
      ST_FIRST_OUT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = cmd_o.emit ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/linear_envelope_generator_unit.sv =====
// Linear attack/release envelope generator.
// Each input transaction on the in_* channel is one tick and yields exactly one
// output transaction on the out_* channel carrying level_o (Q1.15), last_o and
// config_error_o. restart_i = 1 captures the configuration registers, checks
// the lengths against the mode and starts a new envelope at sample zero.
// Registers are written on the cfg_* channel, which is always ready; writes
// take effect at the next restart.
// A plain tick is accepted every cycle while the output is not stalled, and its
// sample is written into the output register. A restart goes through an
// iterative divider that produces one quotient bit per cycle, for the ramp
// step and, in full mode, the release step (two step divisions); a rejected
// configuration skips them. in_stall_o is high while a restart is in progress.
// When the receiver stalls, the output register holds its transaction and one
// further tick is still taken; the next one is then stalled until the output
// drains. After reset the generator is finished: ticks give level 0, last 1.
module linear_envelope_generator_unit import leg_pkg::*; #(
  parameter int LENGTH_BITS   = LENGTH_BITS_DEFAULT,
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write channel.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Tick channel.
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   restart_i,
  // Sample channel.
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [LEVEL_W-1:0]     level_o,
  output logic                   last_o,
  output logic                   config_error_o
);

  leg_cmd_t    cmd;
  leg_status_t status;

  // Registers only matter at restart, so writes are never held off.
  assign cfg_ready_o = 1'b1;

  leg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .restart_i   (restart_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  leg_datapath #(
    .LENGTH_BITS   (LENGTH_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .level_o        (level_o),
    .last_o         (last_o),
    .config_error_o (config_error_o)
  );

endmodule
